[rtl/bsc_pkg.sv]
`default_nettype none

package bsc_pkg;

  localparam int MAX_CHUNK_BITS = 60;
  localparam int ELEM_W = 60;
  localparam int CHUNK_W = 6;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 6'd16;
  localparam int BYTE_BITS = 8;
  localparam logic [3:0] FULL_BYTE = 4'd8;
  localparam logic [1:0] CHUNK_BITS_ADDR = 2'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] valid_bits;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last_element;
  } out_t;

  // handoff from the packer to the result register
  typedef struct packed {
    logic emit;
    out_t word;
  } emit_t;

endpackage

`default_nettype wire

[rtl/bsc_cfg.sv]
`default_nettype none

module bsc_cfg
  import bsc_pkg::*;
#(
  parameter int MAX_BITS = MAX_CHUNK_BITS,
  localparam int CW = $clog2(MAX_BITS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output logic      [CW-1:0] chunk_k,
  output logic               clear
);

  localparam logic [CHUNK_W-1:0] MAX_V = CHUNK_W'(MAX_BITS);

  logic [CHUNK_W-1:0] chunk_bits;
  logic               wr;

  // chunk_bits is the only register, at byte address 0
  assign wr     = psel && penable && pwrite && (paddr == CHUNK_BITS_ADDR);
  assign pready = 1'b1;
  assign clear  = wr;
  assign prdata = {{(32-CHUNK_W){1'b0}}, chunk_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bits <= CHUNK_RESET;
    end else if (wr) begin
      chunk_bits <= pwdata[CHUNK_W-1:0];
    end
  end

  always_comb begin
    if (chunk_bits == '0) begin
      chunk_k = CW'(1);
    end else if (chunk_bits > MAX_V) begin
      chunk_k = CW'(MAX_BITS);
    end else begin
      chunk_k = CW'(chunk_bits);
    end
  end

endmodule

`default_nettype wire

[rtl/bsc_pack.sv]
`default_nettype none

module bsc_pack
  import bsc_pkg::*;
#(
  parameter int MAX_BITS = MAX_CHUNK_BITS,
  localparam int CW = $clog2(MAX_BITS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [CW-1:0] chunk_k,
  input  wire logic          clear,
  input  wire logic          src_valid,
  output logic               src_ready,
  input  wire in_t           src_word,
  input  wire logic          slot_free,
  output emit_t              emit
);

  localparam int PW = MAX_BITS;
  localparam logic [CW-1:0] PW_V = CW'(MAX_BITS);

  // input register: remaining bits of the current word
  logic          busy;
  logic [7:0]    cur_byte;
  logic [3:0]    cur_left;
  logic          cur_last;
  // element under construction
  logic [PW-1:0] pend;
  logic [CW-1:0] pend_cnt;

  logic [3:0]    v_clip;
  logic [CW-1:0] need;
  logic          full;
  logic [7:0]    rest_byte;
  logic [3:0]    rest_left;
  logic          done;
  logic          emits;
  logic          fire;
  logic          accept;
  logic [PW-1:0] merged;
  logic [PW-1:0] kmask;
  logic [CW-1:0] cnt_sum;

  assign v_clip = (src_word.valid_bits > FULL_BYTE) ? FULL_BYTE : src_word.valid_bits;

  assign need      = chunk_k - pend_cnt;
  assign full      = {{(CW > 4 ? CW-4 : 0){1'b0}}, cur_left} >= need;
  assign rest_byte = cur_byte >> need;
  assign rest_left = cur_left - 4'(need);
  assign merged    = pend | (PW'(cur_byte) << pend_cnt);
  assign kmask     = {PW{1'b1}} >> (PW_V - chunk_k);
  assign cnt_sum   = pend_cnt + CW'(cur_left);

  always_comb begin
    if (full) begin
      done = (rest_left == 4'd0) ||
             (({{(CW > 4 ? CW-4 : 0){1'b0}}, rest_left} < chunk_k) && !cur_last);
      emits = 1'b1;
    end else begin
      done  = 1'b1;
      emits = cur_last && (cnt_sum != '0);
    end
  end

  assign fire      = busy && (!emits || slot_free);
  assign src_ready = !busy || (fire && done);
  assign accept    = src_valid && src_ready;

  always_comb begin
    emit.emit = fire && emits;
    emit.word.element = ELEM_W'(merged & kmask);
    emit.word.last_element = full ? (cur_last && rest_left == 4'd0) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pend     <= '0;
      pend_cnt <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fire && done) begin
        busy <= 1'b0;
      end
      if (clear) begin
        pend     <= '0;
        pend_cnt <= '0;
      end else if (fire) begin
        if (full) begin
          if (done && rest_left != 4'd0) begin
            // leftover bits start the next element
            pend     <= PW'(rest_byte);
            pend_cnt <= CW'(rest_left);
          end else begin
            pend     <= '0;
            pend_cnt <= '0;
          end
        end else if (cur_last) begin
          pend     <= '0;
          pend_cnt <= '0;
        end else begin
          pend     <= merged;
          pend_cnt <= cnt_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= src_word.data_byte & (8'hFF >> (FULL_BYTE - v_clip));
      cur_left <= v_clip;
      cur_last <= src_word.last_byte;
    end else if (fire && full) begin
      cur_byte <= rest_byte;
      cur_left <= rest_left;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear |=> pend_cnt == '0)
    else $error("pending count not cleared after chunk width write");

  a_cnt_below_k: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> pend_cnt < chunk_k)
    else $error("pending count reached chunk width");

  a_unfinished_stays: assert property (@(posedge clk) disable iff (rst)
    (fire && !done) |=> busy)
    else $error("word dropped before all elements were sent");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !busy |-> src_ready)
    else $error("packer idle but not taking words");

endmodule

`default_nettype wire

[rtl/bsc_oreg.sv]
`default_nettype none

module bsc_oreg
  import bsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire emit_t emit,
  output logic       slot_free,
  output logic       dst_valid,
  input  wire logic  dst_ready,
  output out_t       dst_word
);

  assign slot_free = !dst_valid || dst_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (emit.emit) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit) begin
      dst_word <= emit.word;
    end
  end

endmodule

`default_nettype wire

[rtl/bit_stream_to_chunks_core.sv]
// Bit stream to chunk repacker.
// src channel: one word per byte of a little-endian bitstring (data_byte,
//   valid_bits low bits used, last_byte on the final byte).
// dst channel: elements of chunk_bits bits (clamped to 1..MAX_BITS),
//   earliest bit in bit 0; the final element of a string carries
//   last_element, a short tail is zero padded.
// APB port: register 0 (address 0) is chunk_bits; a write drops any partly
//   built element. Write only while the block is idle.
// Flow: a word accepted on src is held in the packer's input register, and
//   each element it completes passes through the result register to dst.
//   The packer emits at most one element per cycle, and only while the
//   result register has room, so a byte is held until every element it
//   completes (up to 8 for chunk_bits 1) is sent, plus its tail if it is a
//   last byte. Otherwise one byte is taken every cycle.
// Reset (rst, synchronous) clears the partial element, empties the result
//   register and sets chunk_bits to 16.
// A stalled dst holds the result register; the packer waits only when it
//   has an element to send, and src_ready drops once its input is held.
`default_nettype none

module bit_stream_to_chunks_core
  import bsc_pkg::*;
#(
  parameter int MAX_BITS = MAX_CHUNK_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output logic             src_ready,
  input  wire in_t         src_word,
  output logic             dst_valid,
  input  wire logic        dst_ready,
  output out_t             dst_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CW = $clog2(MAX_BITS + 1);

  logic [CW-1:0] chunk_k;
  logic          clear;
  logic          slot_free;
  emit_t         emit;

  bsc_cfg #(.MAX_BITS(MAX_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .chunk_k (chunk_k),
    .clear   (clear)
  );

  bsc_pack #(.MAX_BITS(MAX_BITS)) u_pack (
    .clk       (clk),
    .rst       (rst),
    .chunk_k   (chunk_k),
    .clear     (clear),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .slot_free (slot_free),
    .emit      (emit)
  );

  bsc_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .slot_free (slot_free),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_word  (dst_word)
  );

endmodule

`default_nettype wire
